/* rtl/rfm_pkg.sv */
// Shared constants, control types and the microcode table of the
// reciprocal frequency meter. No dependencies.
package rfm_pkg;

    // Timestamp width default and fixed arithmetic constants
    localparam int TimeBitsDef = 32;
    localparam int RateBits    = 26;
    localparam int FreqBits    = 32;
    localparam int DivBits     = 32;
    localparam int CntBits     = $clog2(DivBits);
    localparam logic [RateBits-1:0] RateReset = RateBits'(1005000);
    localparam logic [RateBits-1:0] RateMax   = RateBits'(42949672);
    localparam logic [FreqBits-1:0] Scale     = FreqBits'(100);

    // Datapath operations
    localparam logic [2:0] OP_NOP     = 3'd0;
    localparam logic [2:0] OP_CAPTURE = 3'd1;  // take an input beat
    localparam logic [2:0] OP_DIFF    = 3'd2;  // delta, clear phase, load dividend
    localparam logic [2:0] OP_DIVSTEP = 3'd3;  // one restoring division bit
    localparam logic [2:0] OP_FREQWR  = 3'd4;  // store quotient as frequency
    localparam logic [2:0] OP_STORE   = 3'd5;  // store first edge time
    localparam logic [2:0] OP_BUTTON  = 3'd6;  // toggle source, clear
    localparam logic [2:0] OP_EMIT    = 3'd7;  // load output register

    // Jump conditions
    localparam logic [2:0] CND_NEVER    = 3'd0;
    localparam logic [2:0] CND_ALWAYS   = 3'd1;
    localparam logic [2:0] CND_IN_NONE  = 3'd2;
    localparam logic [2:0] CND_BUTTON   = 3'd3;
    localparam logic [2:0] CND_UNSEL    = 3'd4;
    localparam logic [2:0] CND_FIRST    = 3'd5;
    localparam logic [2:0] CND_DZERO    = 3'd6;
    localparam logic [2:0] CND_DIV_MORE = 3'd7;

    // Program steps
    localparam int StepBits = 4;
    localparam logic [StepBits-1:0] STEP_WAIT   = 4'd0;
    localparam logic [StepBits-1:0] STEP_KIND   = 4'd1;
    localparam logic [StepBits-1:0] STEP_SRC    = 4'd2;
    localparam logic [StepBits-1:0] STEP_PHASE  = 4'd3;
    localparam logic [StepBits-1:0] STEP_DIFF   = 4'd4;
    localparam logic [StepBits-1:0] STEP_DIV    = 4'd5;
    localparam logic [StepBits-1:0] STEP_FREQ   = 4'd6;
    localparam logic [StepBits-1:0] STEP_STORE  = 4'd7;
    localparam logic [StepBits-1:0] STEP_BUTTON = 4'd8;
    localparam logic [StepBits-1:0] STEP_EMIT   = 4'd9;
    localparam logic [StepBits-1:0] STEP_LOOP   = 4'd10;

    // One microcode word
    typedef struct packed {
        logic [2:0]          op;
        logic [2:0]          cond;
        logic                hold;    // emit step: stall while output is busy
        logic [StepBits-1:0] target;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic [2:0] op;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic is_button;
        logic unsel;
        logic first;
        logic dzero;
        logic div_more;
        logic out_busy;
    } status_t;

    // Program table
    function automatic ucode_t ucode_rom(input logic [StepBits-1:0] step);
        ucode_t w;
        w = '{op: OP_NOP, cond: CND_ALWAYS, hold: 1'b0, target: STEP_WAIT};
        unique case (step)
            STEP_WAIT:   w = '{OP_CAPTURE, CND_IN_NONE,  1'b0, STEP_WAIT};
            STEP_KIND:   w = '{OP_NOP,     CND_BUTTON,   1'b0, STEP_BUTTON};
            STEP_SRC:    w = '{OP_NOP,     CND_UNSEL,    1'b0, STEP_EMIT};
            STEP_PHASE:  w = '{OP_NOP,     CND_FIRST,    1'b0, STEP_STORE};
            STEP_DIFF:   w = '{OP_DIFF,    CND_DZERO,    1'b0, STEP_EMIT};
            STEP_DIV:    w = '{OP_DIVSTEP, CND_DIV_MORE, 1'b0, STEP_DIV};
            STEP_FREQ:   w = '{OP_FREQWR,  CND_ALWAYS,   1'b0, STEP_EMIT};
            STEP_STORE:  w = '{OP_STORE,   CND_ALWAYS,   1'b0, STEP_EMIT};
            STEP_BUTTON: w = '{OP_BUTTON,  CND_NEVER,    1'b0, STEP_WAIT};
            STEP_EMIT:   w = '{OP_EMIT,    CND_NEVER,    1'b1, STEP_EMIT};
            STEP_LOOP:   w = '{OP_NOP,     CND_ALWAYS,   1'b0, STEP_WAIT};
            default:     w = '{OP_NOP,     CND_ALWAYS,   1'b0, STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/rfm_seq.sv */
// Microcode sequencer: step counter, program table lookup and jumps.
// Depends on rfm_pkg.
module rfm_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  rfm_pkg::status_t status,
    output rfm_pkg::ctrl_t   ctrl
);

    logic [rfm_pkg::StepBits-1:0] step_reg;
    logic [rfm_pkg::StepBits-1:0] step_next;
    rfm_pkg::ucode_t              word;
    logic                         jump;

    // Current control word
    assign word    = rfm_pkg::ucode_rom(step_reg);
    assign ctrl.op = word.op;

    // Condition select
    always_comb
    begin
        unique case (word.cond)
            rfm_pkg::CND_NEVER:    jump = 1'b0;
            rfm_pkg::CND_ALWAYS:   jump = 1'b1;
            rfm_pkg::CND_IN_NONE:  jump = !status.in_valid;
            rfm_pkg::CND_BUTTON:   jump = status.is_button;
            rfm_pkg::CND_UNSEL:    jump = status.unsel;
            rfm_pkg::CND_FIRST:    jump = status.first;
            rfm_pkg::CND_DZERO:    jump = status.dzero;
            rfm_pkg::CND_DIV_MORE: jump = status.div_more;
            default:               jump = 1'b0;
        endcase
    end

    // Next step: hold, jump or fall through
    always_comb
    begin
        priority if (word.hold && status.out_busy)
            step_next = step_reg;
        else if (jump)
            step_next = word.target;
        else
            step_next = step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= rfm_pkg::STEP_WAIT;
        else
            step_reg <= step_next;
    end

endmodule

/* rtl/rfm_dp.sv */
// Datapath: meter state, rate register, bit-serial divider, output register.
// Depends on rfm_pkg; driven by rfm_seq.
module rfm_dp #(
    parameter int TIME_BITS = rfm_pkg::TimeBitsDef
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rfm_pkg::ctrl_t                ctrl,
    output rfm_pkg::status_t              status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rfm_pkg::RateBits-1:0]  cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rfm_pkg::FreqBits-1:0]  m_tdata,
    output logic [1:0]                    m_tuser
);

    localparam int FB = rfm_pkg::FreqBits;
    localparam int CB = rfm_pkg::CntBits;

    // Configuration
    logic [rfm_pkg::RateBits-1:0] rate_reg;
    logic [rfm_pkg::RateBits-1:0] rate_eff;
    logic [FB-1:0]                num;

    // Meter state
    logic                 sel_reg, sel_next;
    logic                 pend_reg, pend_next;
    logic [TIME_BITS-1:0] first_reg, first_next;
    logic [FB-1:0]        freq_reg, freq_next;
    logic                 fresh_reg, fresh_next;

    // Captured beat
    logic                 cmd_reg, src_reg;
    logic [TIME_BITS-1:0] ts_reg;

    // Divider
    logic [TIME_BITS-1:0] dvsr_reg, dvsr_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [FB-1:0]        quot_reg, quot_next;
    logic [CB-1:0]        cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] delta;
    logic [TIME_BITS:0]   rem_sh;
    logic                 ge;

    // Output register
    logic          mv_reg, mv_next;
    logic [FB-1:0] mdata_reg;
    logic          msel_reg, mnew_reg;
    logic          accept;
    logic          emit;

    assign cfg_ready = 1'b1;
    assign s_tready  = (ctrl.op == rfm_pkg::OP_CAPTURE);
    assign accept    = s_tvalid && s_tready;

    // Clamp rate so rate * 100 fits the frequency width
    assign rate_eff = (rate_reg > rfm_pkg::RateMax) ? rfm_pkg::RateMax : rate_reg;
    assign num      = FB'(rate_eff) * rfm_pkg::Scale;

    // Wrapping period and one restoring step
    assign delta  = ts_reg - first_reg;
    assign rem_sh = {rem_reg, quot_reg[FB-1]};
    assign ge     = rem_sh >= {1'b0, dvsr_reg};

    // Status to the sequencer
    assign status.in_valid  = s_tvalid;
    assign status.is_button = cmd_reg;
    assign status.unsel     = (src_reg != sel_reg);
    assign status.first     = !pend_reg;
    assign status.dzero     = (delta == '0);
    assign status.div_more  = (cnt_reg != '0);
    assign status.out_busy  = mv_reg && !m_tready;

    assign emit = (ctrl.op == rfm_pkg::OP_EMIT) && !status.out_busy;

    // Next-state logic per operation
    always_comb
    begin
        sel_next   = sel_reg;
        pend_next  = pend_reg;
        first_next = first_reg;
        freq_next  = freq_reg;
        fresh_next = fresh_reg;
        dvsr_next  = dvsr_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        unique case (ctrl.op)
            rfm_pkg::OP_CAPTURE:
            begin
                if (accept)
                    fresh_next = 1'b0;
            end
            rfm_pkg::OP_DIFF:
            begin
                pend_next = 1'b0;
                dvsr_next = delta;
                rem_next  = '0;
                quot_next = num;
                cnt_next  = CB'(rfm_pkg::DivBits - 1);
            end
            rfm_pkg::OP_DIVSTEP:
            begin
                rem_next  = ge ? TIME_BITS'(rem_sh - {1'b0, dvsr_reg})
                               : rem_sh[TIME_BITS-1:0];
                quot_next = {quot_reg[FB-2:0], ge};
                cnt_next  = cnt_reg - 1'b1;
            end
            rfm_pkg::OP_FREQWR:
            begin
                freq_next  = quot_reg;
                fresh_next = 1'b1;
            end
            rfm_pkg::OP_STORE:
            begin
                first_next = ts_reg;
                pend_next  = 1'b1;
            end
            rfm_pkg::OP_BUTTON:
            begin
                sel_next  = !sel_reg;
                pend_next = 1'b0;
                freq_next = '0;
            end
            rfm_pkg::OP_NOP,
            rfm_pkg::OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        priority if (emit)
            mv_next = 1'b1;
        else if (m_tready)
            mv_next = 1'b0;
        else
            mv_next = mv_reg;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= rfm_pkg::RateReset;
            sel_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            first_reg <= '0;
            freq_reg  <= '0;
            fresh_reg <= 1'b0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rate_reg <= cfg_data;
            sel_reg   <= sel_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
            freq_reg  <= freq_next;
            fresh_reg <= fresh_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tuser[0];
            src_reg <= s_tuser[1];
            ts_reg  <= s_tdata[TIME_BITS-1:0];
        end
        dvsr_reg <= dvsr_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (emit)
        begin
            mdata_reg <= freq_reg;
            msel_reg  <= sel_reg;
            mnew_reg  <= fresh_reg;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = {mnew_reg, msel_reg};

endmodule

/* rtl/reciprocal_frequency_meter.sv */
// Top level of the two-source reciprocal frequency meter.
// Depends on rfm_pkg, rfm_seq and rfm_dp.
//
// Channel  Dir  Handshake             Payload
// s_*      in   s_tvalid / s_tready   tdata: timestamp; tuser: cmd, source
// m_*      out  m_tvalid / m_tready   tdata: freq_hundredths; tuser: selected_source,
//                                     new_reading
// cfg_*    in   cfg_valid / cfg_ready cfg_data: timer_rate_hz
//
// One beat at a time runs through the microcode program. Button and unselected
// edges, a first edge and a zero period skip the divider; a measurement runs it:
// the divider produces one quotient bit per cycle.
// Reset is asynchronous, active low; no clearing pass is needed.
// A result waits in the output register while the next beat is taken; the
// program stalls at its emit step only while that register is still full.
module reciprocal_frequency_meter #(
    parameter int TIME_BITS = rfm_pkg::TimeBitsDef
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rfm_pkg::RateBits-1:0] cfg_data,   // timer_rate_hz
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,    // [31:0] timestamp
    input  logic [1:0]                   s_tuser,    // [0] cmd, [1] source
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rfm_pkg::FreqBits-1:0] m_tdata,    // [31:0] freq_hundredths
    output logic [1:0]                   m_tuser     // [0] selected_source, [1] new_reading
);

    rfm_pkg::ctrl_t   ctrl;
    rfm_pkg::status_t status;

    // Program sequencer
    rfm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Datapath
    rfm_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for reciprocal_frequency_meter: stream driver and monitor
// with an in-bench period/frequency predictor. Depends on rfm_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_top;

    localparam int TimeBits    = rfm_pkg::TimeBitsDef;
    localparam int RateBits    = rfm_pkg::RateBits;
    localparam int FreqBits    = rfm_pkg::FreqBits;
    localparam int LongHold    = 400;   // receiver hold-off, cycles
    localparam int DrainCycles = 50;    // longer than one measurement
    localparam int MaxReports  = 10;

    // Event kinds and source lines as carried in s_tuser
    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_BUTTON = 1'b1;
    localparam logic SRC_GEN    = 1'b0;
    localparam logic SRC_TIMER  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic        src;
        logic [31:0] ts;
    } meter_evt_t;

    typedef struct packed {
        logic [FreqBits-1:0] freq;
        logic                sel;
        logic                fresh;
    } reading_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [RateBits-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata   = '0;   // [31:0] timestamp
    logic [1:0]          s_tuser   = '0;   // [0] cmd, [1] source
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [FreqBits-1:0] m_tdata;          // [31:0] freq_hundredths
    logic [1:0]          m_tuser;          // [0] selected_source, [1] new_reading

    reciprocal_frequency_meter #(
        .TIME_BITS (TimeBits)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Stimulus and expectation stores
    meter_evt_t edge_events[$];
    reading_t   pending_readings[$];

    // Predictor state
    logic [RateBits-1:0] rate_setting = rfm_pkg::RateReset;
    logic                sel_mode     = SRC_GEN;
    logic                edge_pending = 1'b0;
    logic [TimeBits-1:0] edge_time    = '0;
    logic [FreqBits-1:0] freq_held    = '0;

    // Traffic shaping and bookkeeping
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    int   hold_off_seq   = 0;
    int   beats_in       = 0;
    int   mismatch_count = 0;
    int   useful_items   = 0;
    logic gen_sel        = SRC_GEN;   // selection as seen by the stimulus generator

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one event to the predictor state and return the reading it produces
    function automatic reading_t predict_reading(input meter_evt_t e);
        logic [TimeBits-1:0] delta;
        logic [RateBits-1:0] rate;
        logic [63:0]         scaled;
        reading_t            r;
        r.fresh = 1'b0;
        if (e.cmd == CMD_BUTTON)
        begin
            sel_mode     = ~sel_mode;
            edge_pending = 1'b0;
            freq_held    = '0;
        end
        else if (e.src == sel_mode)
        begin
            if (!edge_pending)
            begin
                edge_time    = e.ts[TimeBits-1:0];
                edge_pending = 1'b1;
            end
            else
            begin
                delta = e.ts[TimeBits-1:0] - edge_time;
                if (delta != '0)
                begin
                    rate      = (rate_setting > rfm_pkg::RateMax) ? rfm_pkg::RateMax
                                                                  : rate_setting;
                    scaled    = 64'(rate) * 64'(rfm_pkg::Scale);
                    freq_held = FreqBits'(scaled / 64'(delta));
                    r.fresh   = 1'b1;
                end
                edge_pending = 1'b0;
            end
        end
        r.freq = freq_held;
        r.sel  = sel_mode;
        return r;
    endfunction

    task automatic log_mismatch(input string what, input reading_t want, input reading_t got);
        mismatch_count++;
        if (mismatch_count <= MaxReports)
            $display("%0t %s: exp freq=%0d sel=%0d new=%0d, got freq=%0d sel=%0d new=%0d",
                     $time, what, want.freq, want.sel, want.fresh,
                     got.freq, got.sel, got.fresh);
    endtask

    // Monitor: check output beats first, then predict the input beat taken this edge
    always @(posedge clk)
    begin : monitor
        reading_t got;
        reading_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{freq: m_tdata, sel: m_tuser[0], fresh: m_tuser[1]};
                if (pending_readings.size() == 0)
                    log_mismatch("result with none expected", '0, got);
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.freq !== want.freq || got.sel !== want.sel
                        || got.fresh !== want.fresh)
                        log_mismatch("reading mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
            begin
                pending_readings.push_back(predict_reading(
                    '{cmd: s_tuser[0], src: s_tuser[1], ts: s_tdata}));
                beats_in++;
            end
        end
    end

    // Driver: hold a beat until taken, then offer the next one or idle
    always @(negedge clk)
    begin : driver
        int         beats_seen;
        meter_evt_t e;
        if (rst_n && (!s_tvalid || beats_in != beats_seen))
        begin
            beats_seen = beats_in;
            if (edge_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                e = edge_events.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= e.ts;
                s_tuser  <= {e.src, e.cmd};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random backpressure plus an occasional long hold-off
    always @(negedge clk)
    begin : receiver
        int hold_seen;
        int hold_left;
        if (hold_off_seq != hold_seen)
        begin
            hold_seen = hold_off_seq;
            hold_left = LongHold;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic add_evt(input logic cmd, input logic src, input logic [31:0] ts);
        edge_events.push_back('{cmd: cmd, src: src, ts: ts});
        if (cmd == CMD_BUTTON || src == gen_sel)
            useful_items++;
        if (cmd == CMD_BUTTON)
            gen_sel = ~gen_sel;
    endtask

    // Mostly edge pairs on the selected source, plus buttons and stray edges
    task automatic random_events(input int count);
        int          start;
        int          pick;
        logic [31:0] t0;
        logic [31:0] delta;
        start = useful_items;
        while (useful_items - start < count)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                t0 = $urandom;
                case ($urandom_range(9))
                    0:       delta = '0;
                    1, 2:    delta = $urandom_range(16, 1);
                    3, 4, 5: delta = $urandom_range(65535, 17);
                    default: delta = $urandom;
                endcase
                add_evt(CMD_EDGE, gen_sel, t0);
                if ($urandom_range(4) == 0)
                    add_evt(CMD_EDGE, ~gen_sel, $urandom);
                add_evt(CMD_EDGE, gen_sel, t0 + delta);
            end
            else if (pick < 77)
                add_evt(CMD_BUTTON, 1'($urandom), $urandom);
            else if (pick < 89)
                add_evt(CMD_EDGE, ~gen_sel, $urandom);
            else
                add_evt(CMD_EDGE, gen_sel, $urandom);
        end
    endtask

    task automatic write_rate(input logic [RateBits-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rate_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (edge_events.size() != 0 || s_tvalid || pending_readings.size() != 0)
            @(negedge clk);
    endtask

    // Main sequence
    initial
    begin
        logic [RateBits-1:0] rate_plan[8];
        rate_plan[0] = rfm_pkg::RateReset;
        rate_plan[1] = '0;
        rate_plan[2] = RateBits'(1);
        rate_plan[3] = rfm_pkg::RateMax;
        rate_plan[4] = '1;                 // above range, clamps
        rate_plan[5] = RateBits'($urandom_range(int'(rfm_pkg::RateMax) - 1, 2));
        rate_plan[6] = RateBits'($urandom);
        rate_plan[7] = rfm_pkg::RateReset;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset rate
        add_evt(CMD_EDGE, SRC_TIMER, '0);              // unselected source
        add_evt(CMD_EDGE, SRC_GEN, 32'hFFFF_FFF0);     // first edge
        add_evt(CMD_EDGE, SRC_TIMER, 32'h1234_5678);   // unselected while pending
        add_evt(CMD_EDGE, SRC_GEN, 32'h0000_0010);     // counter wraps
        add_evt(CMD_EDGE, SRC_GEN, 32'd5);
        add_evt(CMD_EDGE, SRC_GEN, 32'd5);             // zero period keeps freq
        add_evt(CMD_EDGE, SRC_GEN, '0);
        add_evt(CMD_EDGE, SRC_GEN, 32'd1);             // shortest period
        add_evt(CMD_EDGE, SRC_GEN, '0);
        add_evt(CMD_EDGE, SRC_GEN, '1);                // longest period
        add_evt(CMD_BUTTON, SRC_TIMER, '1);            // switch to timer source
        add_evt(CMD_EDGE, SRC_GEN, 32'd77);            // now unselected
        add_evt(CMD_EDGE, SRC_TIMER, 32'd100);
        add_evt(CMD_BUTTON, SRC_GEN, '0);              // clears mid-measurement
        add_evt(CMD_EDGE, SRC_GEN, 32'hAAAA_AAAA);
        add_evt(CMD_EDGE, SRC_GEN, 32'hAAAA_AAAA + 32'd1000);
        add_evt(CMD_BUTTON, SRC_GEN, 32'h5555_5555);
        add_evt(CMD_EDGE, SRC_TIMER, 32'h5555_5555);
        add_evt(CMD_EDGE, SRC_TIMER, 32'h5556_5555);
        add_evt(CMD_BUTTON, SRC_TIMER, '0);
        wait_drained();

        // Random phases, one rate setting each
        for (int seg = 0; seg < 8; seg++)
        begin
            write_rate(rate_plan[seg]);
            @(posedge clk);
            if (seg < 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 66;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // two presses restore the selection and clear the phase; then a one-tick period
            add_evt(CMD_BUTTON, SRC_GEN, '0);
            add_evt(CMD_BUTTON, SRC_TIMER, '1);
            add_evt(CMD_EDGE, gen_sel, 32'h8000_0000);
            add_evt(CMD_EDGE, gen_sel, 32'h8000_0001);
            random_events(135);
            if (seg == 1)
                hold_off_seq++;
            wait_drained();
        end

        repeat (DrainCycles) @(negedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("reciprocal_frequency_meter regression: pass");
        else
            $display("reciprocal_frequency_meter regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("reciprocal_frequency_meter regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/rfm_pkg.sv
rtl/rfm_seq.sv
rtl/rfm_dp.sv
rtl/reciprocal_frequency_meter.sv
test/tb_top.sv
